@@ src/pkld_pkg.sv @@
// ----------------------------------------------------------------------------
// pkld_pkg: shared types and constants for the per-key LED decay table
// Opcodes, register indexes, reset values, item structs and the
// reciprocal used for the divide by 1000.
// ----------------------------------------------------------------------------
package pkld_pkg;

  // default number of keys
  localparam int NUM_KEYS_DEF = 88;

  // opcodes
  localparam logic [1:0] OP_NOTE_ON  = 2'd0;
  localparam logic [1:0] OP_NOTE_OFF = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;
  localparam logic [1:0] OP_READ     = 2'd3;

  // configuration port
  localparam int CFG_AW = 2;
  localparam int CFG_DW = 15;
  localparam logic [CFG_AW-1:0] CFG_LOWEST_PITCH   = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_PEAK           = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_HELD_DECAY     = 2'd2;
  localparam logic [CFG_AW-1:0] CFG_RELEASED_DECAY = 2'd3;

  // register reset values
  localparam logic [6:0]  LOWEST_PITCH_RST   = 7'd21;
  localparam logic [14:0] PEAK_RST           = 15'd32767;
  localparam logic [7:0]  HELD_DECAY_RST     = 8'd30;
  localparam logic [7:0]  RELEASED_DECAY_RST = 8'd80;

  // field widths
  localparam int BRIGHT_W = 15;
  localparam int DECAY_W  = 8;
  localparam int ELAPSED_W = 16;
  localparam int PROD1_W  = ELAPSED_W + DECAY_W;   // elapsed * decay

  // floor(x*256/1000) = floor(32x/125) = floor(x*RECIP / 2^31) for x < 2^24
  localparam int RECIP_W = 30;
  localparam logic [RECIP_W-1:0] RECIP = 30'd549755814;
  localparam int RECIP_SHIFT = 31;
  localparam int PROD2_W = PROD1_W + RECIP_W;
  localparam int DEC_W   = PROD2_W - RECIP_SHIFT;

  typedef struct packed {
    logic [1:0]           op;
    logic [6:0]           pitch;
    logic [ELAPSED_W-1:0] elapsed_ms;
  } item_t;

  typedef struct packed {
    logic [6:0]          key_index;
    logic [BRIGHT_W-1:0] brightness;
    logic                key_valid;
  } result_t;

endpackage

@@ src/pkld_ram.sv @@
// ----------------------------------------------------------------------------
// pkld_ram: per-key store with valid bits
// One write and one read port, registered read data. An entry never
// written since reset reads as zero.
// ----------------------------------------------------------------------------
module pkld_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 88,
  parameter int AW    = 7
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [W-1:0] rd_q;
  logic rd_vld;

  // array write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  // valid bits, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      rd_vld <= vld[raddr];
    end
  end

  assign rdata = rd_vld ? rd_q : '0;

endmodule

@@ src/pkld_decay.sv @@
// ----------------------------------------------------------------------------
// pkld_decay: brightness decrement pipeline
// Two multiply stages then a saturating subtract; produces the write
// back for one key per cycle.
// ----------------------------------------------------------------------------
module pkld_decay #(
  parameter int AW = 7
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_vld,
  input  logic [AW-1:0]                  in_addr,
  input  logic [pkld_pkg::DECAY_W-1:0]   decay,
  input  logic [pkld_pkg::BRIGHT_W-1:0]  bright,
  input  logic [pkld_pkg::ELAPSED_W-1:0] elapsed,
  output logic                           wr_vld,
  output logic [AW-1:0]                  wr_addr,
  output logic [pkld_pkg::BRIGHT_W-1:0]  wr_bright,
  output logic                           active
);
  import pkld_pkg::*;

  logic               v1, v2;
  logic [AW-1:0]      a1, a2;
  logic [PROD1_W-1:0] x1;
  logic [PROD2_W-1:0] p2;
  logic [BRIGHT_W-1:0] b1, b2;
  logic [DEC_W-1:0]   dec;

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= in_vld;
      v2 <= v1;
    end
  end

  // stage 1: elapsed * decay; stage 2: times reciprocal of 125/32
  always_ff @(posedge clk) begin
    a1 <= in_addr;
    b1 <= bright;
    x1 <= PROD1_W'(elapsed) * PROD1_W'(decay);
    a2 <= a1;
    b2 <= b1;
    p2 <= PROD2_W'(x1) * PROD2_W'(RECIP);
  end

  // saturating subtract
  assign dec       = p2[PROD2_W-1:RECIP_SHIFT];
  assign wr_vld    = v2;
  assign wr_addr   = a2;
  assign wr_bright = (DEC_W'(b2) > dec) ? (b2 - dec[BRIGHT_W-1:0]) : '0;
  assign active    = v1 | v2;

endmodule

@@ src/per_key_led_decay_table_top.sv @@
// ----------------------------------------------------------------------------
// per_key_led_decay_table_top: per-key LED brightness and decay table
// Note-on/off update one key, a tick decays every key, a read returns
// one key's brightness.
//
//   channel  signals                       direction  handshake
//   item     start, busy, item             in         start && !busy
//   result   done, result                  out        done, one cycle
//   config   cfg_we, cfg_addr, cfg_data    in         cfg_we
//
// Note-on and note-off write the stores at acceptance; a read's result appears
// on done the cycle after acceptance.
// A tick walks the key store one entry per cycle through the read port of
// the two memories and the decay pipeline; busy holds until the last write back.
// Reset clears the registers to defaults and the stores to zero at once.
// The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module per_key_led_decay_table_top #(
  parameter int NUM_KEYS = pkld_pkg::NUM_KEYS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  pkld_pkg::item_t             item,
  output logic                        done,
  output pkld_pkg::result_t           result,
  input  logic                        cfg_we,
  input  logic [pkld_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [pkld_pkg::CFG_DW-1:0] cfg_data
);
  import pkld_pkg::*;

  localparam int KEY_AW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_TICK = 1'b1;

  // configuration registers
  logic [6:0]          lowest_pitch;
  logic [BRIGHT_W-1:0] peak_brightness;
  logic [DECAY_W-1:0]  held_decay;
  logic [DECAY_W-1:0]  released_decay;

  always_ff @(posedge clk) begin
    if (rst) begin
      lowest_pitch    <= LOWEST_PITCH_RST;
      peak_brightness <= PEAK_RST;
      held_decay      <= HELD_DECAY_RST;
      released_decay  <= RELEASED_DECAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_LOWEST_PITCH:   lowest_pitch    <= cfg_data[6:0];
        CFG_PEAK:           peak_brightness <= cfg_data[BRIGHT_W-1:0];
        CFG_HELD_DECAY:     held_decay      <= cfg_data[DECAY_W-1:0];
        CFG_RELEASED_DECAY: released_decay  <= cfg_data[DECAY_W-1:0];
        default: ;
      endcase
    end
  end

  // pitch to key mapping
  logic [6:0]        key_diff;
  logic              key_ok;
  logic [KEY_AW-1:0] key_addr;
  logic              accept;

  assign key_diff = item.pitch - lowest_pitch;
  assign key_ok   = (item.pitch >= lowest_pitch) && ({1'b0, key_diff} < 8'(NUM_KEYS));
  assign key_addr = key_diff[KEY_AW-1:0];
  assign accept   = start && !busy;

  // sequencer state
  logic              state;
  logic [KEY_AW-1:0] cnt;
  logic [ELAPSED_W-1:0] elapsed;
  logic              v0;
  logic [KEY_AW-1:0] a0;
  logic              rd_pending;
  logic              rd_ok;
  logic [6:0]        rd_key;
  logic              dec_active;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      v0         <= 1'b0;
      rd_pending <= 1'b0;
    end else begin
      v0         <= 1'b0;
      rd_pending <= accept && (item.op == OP_READ);
      unique case (state)
        ST_IDLE: begin
          if (accept && (item.op == OP_TICK)) begin
            state <= ST_TICK;
            cnt   <= '0;
          end
        end
        ST_TICK: begin
          v0  <= 1'b1;
          cnt <= cnt + KEY_AW'(1);
          if (cnt == KEY_AW'(NUM_KEYS - 1)) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    a0 <= cnt;
    if (accept) begin
      elapsed <= item.elapsed_ms;
      rd_ok   <= key_ok;
      rd_key  <= key_diff;
    end
  end

  assign busy = (state == ST_TICK) || v0 || dec_active;

  // memory ports
  logic                b_we, d_we;
  logic [KEY_AW-1:0]   b_waddr, d_waddr, raddr;
  logic [BRIGHT_W-1:0] b_wdata, b_rdata;
  logic [DECAY_W-1:0]  d_wdata, d_rdata;
  logic                wr_vld;
  logic [KEY_AW-1:0]   wr_addr;
  logic [BRIGHT_W-1:0] wr_bright;
  logic                note_on, key_release;

  assign note_on     = accept && key_ok && (item.op == OP_NOTE_ON);
  assign key_release = accept && key_ok && (item.op == OP_NOTE_OFF);
  assign raddr    = (state == ST_TICK) ? cnt : key_addr;
  assign b_we     = note_on || wr_vld;
  assign b_waddr  = wr_vld ? wr_addr : key_addr;
  assign b_wdata  = wr_vld ? wr_bright : peak_brightness;
  assign d_we     = note_on || key_release;
  assign d_waddr  = key_addr;
  assign d_wdata  = note_on ? held_decay : released_decay;

  pkld_ram #(.W(BRIGHT_W), .DEPTH(NUM_KEYS), .AW(KEY_AW)) u_bright_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (b_wdata),
    .raddr (raddr),
    .rdata (b_rdata)
  );

  pkld_ram #(.W(DECAY_W), .DEPTH(NUM_KEYS), .AW(KEY_AW)) u_decay_ram (
    .clk   (clk),
    .rst   (rst),
    .we    (d_we),
    .waddr (d_waddr),
    .wdata (d_wdata),
    .raddr (raddr),
    .rdata (d_rdata)
  );

  pkld_decay #(.AW(KEY_AW)) u_decay (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (v0),
    .in_addr   (a0),
    .decay     (d_rdata),
    .bright    (b_rdata),
    .elapsed   (elapsed),
    .wr_vld    (wr_vld),
    .wr_addr   (wr_addr),
    .wr_bright (wr_bright),
    .active    (dec_active)
  );

  // read result
  assign done              = rd_pending;
  assign result.key_index  = rd_ok ? rd_key : '0;
  assign result.brightness = rd_ok ? b_rdata : '0;
  assign result.key_valid  = rd_ok;

endmodule

@@ src/pkld_chk.sv @@
// ----------------------------------------------------------------------------
// pkld_chk: port-level checks for the per-key LED decay table
// Relates accepted items to result strobes and busy.
// ----------------------------------------------------------------------------
module pkld_chk (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input pkld_pkg::item_t   item,
  input logic              done,
  input pkld_pkg::result_t result
);
  import pkld_pkg::*;

  logic acc;
  assign acc = start && !busy;

  // every accepted read gives a result next cycle
  a_read_done: assert property (@(posedge clk) disable iff (rst)
    acc && (item.op == OP_READ) |=> done)
    else $error("read item gave no result");

  // a result only follows an accepted read
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && (item.op == OP_READ)))
    else $error("result without a read item");

  // a tick keeps the block busy
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    acc && (item.op == OP_TICK) |=> busy)
    else $error("tick item did not raise busy");

  // an unmapped key reads as all zero
  a_invalid_zero: assert property (@(posedge clk) disable iff (rst)
    done && !result.key_valid |-> (result.brightness == '0) && (result.key_index == '0))
    else $error("unmapped key gave nonzero fields");

endmodule

bind per_key_led_decay_table_top pkld_chk u_pkld_chk (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);
